FILE: design/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ITER_W           = 6;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 32;
    localparam int CW               = 40;   // cordic x/y width
    localparam int ZW               = 34;   // cordic angle width

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WHEELBASE = 1'd1;

    localparam logic [1:0] KIND_POSE  = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [15:0] GAIN_RST      = 16'd256;
    localparam logic [31:0] WHEELBASE_RST = 32'd65536;
    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [31:0] THREE_QUARTER = 32'hC000_0000;
    localparam logic [31:0] ROUND_HALF    = 32'h0000_8000;
    localparam logic [63:0] SQRT_TOP_BIT  = 64'h4000_0000_0000_0000;
    localparam logic signed [56:0] INV_GAIN   = 57'sd39797;
    localparam logic signed [56:0] GAIN_ROUND = 57'sd32768;
    localparam logic [ITER_W-1:0]  SQRT_LAST  = 6'd31;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_POSE, S_PATH,
        S_V1_LOAD, S_V1_RUN, S_R1_LOAD, S_R1_RUN, S_GAIN1,
        S_SQ_LK, S_SQ_MAG, S_SQRT_LOAD, S_SQRT_RUN,
        S_V2_LOAD, S_V2_RUN, S_R2_LOAD, S_R2_RUN, S_GAIN2,
        S_V3_LOAD, S_V3_RUN, S_STEER, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_POSE, OP_PATH,
        OP_V1_LOAD, OP_R1_LOAD, OP_V2_LOAD, OP_R2_LOAD, OP_V3_LOAD,
        OP_STEP, OP_GAIN1, OP_GAIN2, OP_SQ_LK, OP_SQ_MAG,
        OP_SQRT_STEP, OP_STEER
    } t_op;

    typedef struct packed {
        logic       load;
        logic       emit;
        t_op        op;
        logic [4:0] it;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       query_ok;
        logic       clamped;
    } t_status;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/pps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ctrl
// sequencer: walks one request through the shared cordic, squarer and root
// ----------------------------------------------------------------------------
module pps_ctrl
    import pps_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  wire     i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [ITER_W-1:0] STEP_LAST = ITER_W'(CORDIC_STEPS - 1);

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_it, n_it;
    logic              n_out_valid;
    logic              w_can_emit;

    assign w_can_emit = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_it        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_it        <= n_it;
            o_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_it    = r_it;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_DISP;
            S_DISP: begin
                case (i_status.kind)
                    KIND_POSE:  n_state = S_POSE;
                    KIND_PATH:  n_state = S_PATH;
                    KIND_QUERY: n_state = i_status.query_ok ? S_V1_LOAD : S_FINISH;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_POSE, S_PATH: n_state = S_FINISH;
            S_V1_LOAD: begin n_state = S_V1_RUN; n_it = '0; end
            S_V1_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == STEP_LAST) n_state = S_R1_LOAD;
            end
            S_R1_LOAD: begin n_state = S_R1_RUN; n_it = '0; end
            S_R1_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == STEP_LAST) n_state = S_GAIN1;
            end
            S_GAIN1:     n_state = S_SQ_LK;
            S_SQ_LK:     n_state = S_SQ_MAG;
            S_SQ_MAG:    n_state = S_SQRT_LOAD;
            S_SQRT_LOAD: begin
                n_it    = '0;
                n_state = i_status.clamped ? S_V2_LOAD : S_SQRT_RUN;
            end
            S_SQRT_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == SQRT_LAST) n_state = S_V2_LOAD;
            end
            S_V2_LOAD: begin n_state = S_V2_RUN; n_it = '0; end
            S_V2_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == STEP_LAST) n_state = S_R2_LOAD;
            end
            S_R2_LOAD: begin n_state = S_R2_RUN; n_it = '0; end
            S_R2_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == STEP_LAST) n_state = S_GAIN2;
            end
            S_GAIN2:     n_state = S_V3_LOAD;
            S_V3_LOAD: begin n_state = S_V3_RUN; n_it = '0; end
            S_V3_RUN: begin
                n_it = r_it + 1'b1;
                if (r_it == STEP_LAST) n_state = S_STEER;
            end
            S_STEER:     n_state = S_FINISH;
            S_FINISH:    if (w_can_emit) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '{load: 1'b0, emit: 1'b0, op: OP_NONE, it: r_it[4:0]};
        o_in_stall  = 1'b1;
        n_out_valid = o_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_POSE:      o_cmd.op = OP_POSE;
            S_PATH:      o_cmd.op = OP_PATH;
            S_V1_LOAD:   o_cmd.op = OP_V1_LOAD;
            S_R1_LOAD:   o_cmd.op = OP_R1_LOAD;
            S_V2_LOAD:   o_cmd.op = OP_V2_LOAD;
            S_R2_LOAD:   o_cmd.op = OP_R2_LOAD;
            S_V3_LOAD:   o_cmd.op = OP_V3_LOAD;
            S_V1_RUN, S_R1_RUN, S_V2_RUN, S_R2_RUN, S_V3_RUN: o_cmd.op = OP_STEP;
            S_GAIN1:     o_cmd.op = OP_GAIN1;
            S_GAIN2:     o_cmd.op = OP_GAIN2;
            S_SQ_LK:     o_cmd.op = OP_SQ_LK;
            S_SQ_MAG:    o_cmd.op = OP_SQ_MAG;
            S_SQRT_RUN:  o_cmd.op = OP_SQRT_STEP;
            S_STEER:     o_cmd.op = OP_STEER;
            S_FINISH: begin
                o_cmd.emit = w_can_emit;
                if (w_can_emit) n_out_valid = 1'b1;
            end
            default:     o_cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/pps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pps_dp
// state, configuration, shared cordic, squarer, bit-serial root, result register
// ----------------------------------------------------------------------------
module pps_dp
    import pps_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire [1:0]              i_kind,
    input  wire signed [31:0]      i_pose_x,
    input  wire signed [31:0]      i_pose_y,
    input  wire signed [15:0]      i_pose_heading,
    input  wire [31:0]             i_speed,
    input  wire signed [31:0]      i_waypoint_x,
    input  wire signed [31:0]      i_waypoint_y,
    input  wire [31:0]             i_path_distance,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic signed [15:0]     o_steer_angle,
    output logic                   o_angle_valid,
    output logic                   o_is_active,
    output logic                   o_radicand_clamped
);

    // configuration and block state
    logic [15:0]        r_gain;
    logic [31:0]        r_wb;
    logic signed [31:0] r_rx, r_ry, r_sx, r_sy, r_ex, r_ey;
    logic [15:0]        r_head;
    logic [31:0]        r_lk, r_prior;
    logic               r_active;

    // latched request
    logic [1:0]         r_kind;
    logic signed [31:0] r_px, r_py, r_wx, r_wy;
    logic [15:0]        r_ph;
    logic [31:0]        r_speed, r_dist;

    // query working registers
    logic signed [CW-1:0] r_cx, r_cy, r_c, r_ysin;
    logic signed [ZW-1:0] r_cz;
    logic                 r_vec, r_czero;
    logic [31:0]          r_th;
    logic [CW-1:0]        r_mag;
    logic [63:0]          r_lk2, r_rem, r_res, r_bit;
    logic [15:0]          r_q_steer;
    logic                 r_q_valid, r_q_clamp;

    logic signed [CW-1:0] w_dx, w_dy, w_ox, w_oy, ld_x, ld_y, v_x, v_y, r_x, r_y;
    logic signed [CW-1:0] xs, ys, st_x, st_y, w_g;
    logic signed [ZW-1:0] st_z, at, rz;
    logic signed [56:0]   g_prod;
    logic [31:0]          zv, ld_a, ra, w_steer;
    logic                 v_zero, flip, up;
    logic [47:0]          p_prod;
    logic [31:0]          p_lk;
    logic [63:0]          s_sum, m_sq;
    logic [CW-1:0]        w_mag;

    assign o_status.kind     = r_kind;
    assign o_status.query_ok = r_active && ((r_sx != r_ex) || (r_sy != r_ey));
    assign o_status.clamped  = r_q_clamp;

    always_comb begin
        w_dx = CW'(r_ex) - CW'(r_sx);
        w_dy = CW'(r_ey) - CW'(r_sy);
        w_ox = CW'(r_rx) - CW'(r_sx);
        w_oy = CW'(r_ry) - CW'(r_sy);
        zv   = r_czero ? 32'd0 : r_cz[31:0];

        ld_x = w_dx;
        ld_y = w_dy;
        ld_a = '0;
        case (i_cmd.op)
            OP_R1_LOAD: begin ld_x = w_ox; ld_y = w_oy; ld_a = 32'd0 - zv; end
            OP_V2_LOAD: begin ld_x = {8'd0, r_res[31:0]}; ld_y = -r_c; end
            OP_R2_LOAD: begin
                ld_x = {7'd0, r_wb, 1'b0};
                ld_y = '0;
                ld_a = r_th + zv - {r_head, 16'd0};
            end
            OP_V3_LOAD: begin ld_x = {8'd0, r_lk}; ld_y = r_ysin; end
            default:    ld_a = '0;
        endcase

        // vectoring entry: fold into the right half plane
        v_zero = (ld_x == '0) && (ld_y == '0);
        v_x    = ld_x[CW-1] ? -ld_x : ld_x;
        v_y    = ld_x[CW-1] ? -ld_y : ld_y;
        // rotation entry: fold angle into the right half plane
        flip = (ld_a >= QUARTER_TURN) && (ld_a < THREE_QUARTER);
        r_x  = flip ? -ld_x : ld_x;
        r_y  = flip ? -ld_y : ld_y;
        ra   = flip ? ld_a + HALF_TURN : ld_a;
        rz   = ZW'(signed'(ra));

        // one micro-rotation
        xs   = r_cx >>> i_cmd.it;
        ys   = r_cy >>> i_cmd.it;
        at   = ZW'(atan_entry(i_cmd.it));
        up   = r_vec ? (r_cy > 40'sd0) : r_cz[ZW-1];
        st_x = up ? r_cx + ys : r_cx - ys;
        st_y = up ? r_cy - xs : r_cy + xs;
        st_z = up ? r_cz + at : r_cz - at;

        // cordic gain removal with rounding
        g_prod = 57'(r_cy) * INV_GAIN + GAIN_ROUND;
        w_g    = g_prod[55:16];
        w_mag  = r_c[CW-1] ? unsigned'(-r_c) : unsigned'(r_c);

        p_prod = r_gain * r_speed;
        p_lk   = (p_prod[47:40] != 8'd0) ? 32'hFFFF_FFFF : p_prod[39:8];

        s_sum   = r_res + r_bit;
        m_sq    = r_mag[31:0] * r_mag[31:0];
        w_steer = zv + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_wb     <= WHEELBASE_RST;
            r_rx     <= '0;
            r_ry     <= '0;
            r_head   <= '0;
            r_lk     <= '0;
            r_prior  <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_ex     <= '0;
            r_ey     <= '0;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GAIN:      r_gain <= i_cfg_data[15:0];
                    REG_WHEELBASE: r_wb   <= i_cfg_data;
                    default:       r_wb   <= r_wb;
                endcase
            end
            if (i_cmd.op == OP_POSE) begin
                r_rx     <= r_px;
                r_ry     <= r_py;
                r_head   <= r_ph;
                r_lk     <= p_lk;
                r_prior  <= '0;
                r_ex     <= r_px;
                r_ey     <= r_py;
                r_active <= 1'b0;
            end
            if (i_cmd.op == OP_PATH) begin
                if ((r_prior <= r_lk) && (r_dist >= r_lk)) begin
                    r_sx     <= r_ex;
                    r_sy     <= r_ey;
                    r_ex     <= r_wx;
                    r_ey     <= r_wy;
                    r_active <= 1'b1;
                end
                r_prior <= r_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_px      <= i_pose_x;
            r_py      <= i_pose_y;
            r_ph      <= i_pose_heading;
            r_speed   <= i_speed;
            r_wx      <= i_waypoint_x;
            r_wy      <= i_waypoint_y;
            r_dist    <= i_path_distance;
            r_q_steer <= '0;
            r_q_valid <= 1'b0;
            r_q_clamp <= 1'b0;
        end
        case (i_cmd.op)
            OP_V1_LOAD, OP_V2_LOAD, OP_V3_LOAD: begin
                r_vec   <= 1'b1;
                r_czero <= v_zero;
                r_cx    <= v_x;
                r_cy    <= v_y;
                r_cz    <= ld_x[CW-1] ? ZW'(HALF_TURN) : '0;
            end
            OP_R1_LOAD, OP_R2_LOAD: begin
                if (i_cmd.op == OP_R1_LOAD) r_th <= zv;
                r_vec   <= 1'b0;
                r_czero <= 1'b0;
                r_cx    <= r_x;
                r_cy    <= r_y;
                r_cz    <= rz;
            end
            OP_STEP: begin
                if (!(r_vec && r_czero)) begin
                    r_cx <= st_x;
                    r_cy <= st_y;
                    r_cz <= st_z;
                end
            end
            OP_GAIN1: r_c    <= w_g;
            OP_GAIN2: r_ysin <= w_g;
            OP_SQ_LK: begin
                r_lk2 <= r_lk * r_lk;
                r_mag <= w_mag;
            end
            OP_SQ_MAG: begin
                r_q_clamp <= r_mag > {8'd0, r_lk};
                r_rem     <= r_lk2 - m_sq;
                r_res     <= '0;
                r_bit     <= SQRT_TOP_BIT;
            end
            OP_SQRT_STEP: begin
                if (r_rem >= s_sum) begin
                    r_rem <= r_rem - s_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_STEER: begin
                r_q_steer <= w_steer[31:16];
                r_q_valid <= 1'b1;
            end
            default: r_vec <= r_vec;
        endcase
        if (i_cmd.emit) begin
            o_steer_angle      <= signed'(r_q_steer);
            o_angle_valid      <= r_q_valid;
            o_is_active        <= r_active;
            o_radicand_clamped <= r_q_clamp;
        end
    end

endmodule
`default_nettype wire

FILE: design/pure_pursuit_steering.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// pure pursuit steering unit, fixed point
// ----------------------------------------------------------------------------
// one request at a time, one result per request. pose and path requests update
// the block state and then finish. a query on an active segment makes five
// passes through the single shared cordic unit, one micro-rotation a cycle,
// and a bit-serial square root. a query whose lookahead circle misses the
// segment line skips the square root. a query on an inactive or zero-length
// segment, and the unused kind, go straight to the finish with no angle.
// the finished result sits in an output register, so a new request is taken
// while the previous result still waits. configuration is a plain write port,
// index 0 the lookahead gain, index 1 the wheelbase length.
module pure_pursuit_steering
    import pps_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire [1:0]            i_kind,
    input  wire signed [31:0]    i_pose_x,
    input  wire signed [31:0]    i_pose_y,
    input  wire signed [15:0]    i_pose_heading,
    input  wire [31:0]           i_speed,
    input  wire signed [31:0]    i_waypoint_x,
    input  wire signed [31:0]    i_waypoint_y,
    input  wire [31:0]           i_path_distance,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic signed [15:0]   o_steer_angle,
    output logic                 o_angle_valid,
    output logic                 o_is_active,
    output logic                 o_radicand_clamped
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    pps_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // state, arithmetic and result register
    pps_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_kind             (i_kind),
        .i_pose_x           (i_pose_x),
        .i_pose_y           (i_pose_y),
        .i_pose_heading     (i_pose_heading),
        .i_speed            (i_speed),
        .i_waypoint_x       (i_waypoint_x),
        .i_waypoint_y       (i_waypoint_y),
        .i_path_distance    (i_path_distance),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_steer_angle      (o_steer_angle),
        .o_angle_valid      (o_angle_valid),
        .o_is_active        (o_is_active),
        .o_radicand_clamped (o_radicand_clamped)
    );

    // one request in flight: the input side closes right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // a valid angle only comes from an active segment
    a_valid_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_angle_valid) |-> o_is_active)
        else $error("valid angle on inactive segment");

    // results that are not valid queries carry no angle and no clamp flag
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_angle_valid) |-> (o_steer_angle == 16'sd0 && !o_radicand_clamped))
        else $error("stray angle or clamp flag on non-query result");

endmodule
`default_nettype wire
